@@ design/assert_macros.svh @@
// Assertion macros shared by the checker files.
// Clocked on i_clk; the first form is gated by the active-low reset i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check while out of reset.
`define PQST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check at every edge, reset included.
`define PQST_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ design/pqst_pkg.sv @@
// Package for the paren/quote/space tokenizer: scan modes, token kinds,
// special byte codes, result flags and byte classification functions.
package pqst_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_WORD  = 3'd1,
        MODE_GROUP = 3'd2,
        MODE_DQ    = 3'd3,
        MODE_SQ    = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        KIND_NONE  = 3'd0,
        KIND_WORD  = 3'd1,
        KIND_GROUP = 3'd2,
        KIND_DQ    = 3'd3,
        KIND_SQ    = 3'd4
    } t_kind;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef struct packed {
        logic  ovf;
        logic  unterm;
        logic  ended;
        logic  close;
        logic  start;
        t_kind kind;
    } t_result;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic ends_word(input logic [7:0] c);
        return is_blank(c) || (c == CH_LPAREN) || (c == CH_RPAREN) ||
               (c == CH_DQUOTE) || (c == CH_SQUOTE);
    endfunction

endpackage

@@ design/paren_quote_space_tokenizer_unit.sv @@
// Tokenizer top level: stream in, one marked byte out per byte in.
// Depends on pqst_pkg and pqst_step.
//
// Takes one byte per clock and returns it in the next cycle with its token
// kind and start/close/word-ended/unterminated/overflow flags. The scan mode
// and nesting depth are worked out combinationally by pqst_step, so a byte can
// be accepted on every clock; the one output register frees up in the same
// cycle it is taken, so throughput stays one byte per clock while the
// downstream side is ready. tlast on the input marks the end of a string and
// closes any open token. Depth saturates at MAX_NEST.
module paren_quote_space_tokenizer_unit import pqst_pkg::*; #(
    parameter int MAX_NEST = 255
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,  // [7:0] char_in
    input  logic       i_s_tlast,  // last_byte
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,  // [7:0] char_out
    output logic [7:0] o_m_tuser   // [2:0] token_kind, [3] token_start, [4] token_close,
                                   // [5] word_ended_before, [6] unterminated,
                                   // [7] depth_overflow
);

    localparam int DEPTH_W = $clog2(MAX_NEST + 1);

    t_mode              r_mode;
    t_mode              n_mode;
    logic [DEPTH_W-1:0] r_depth;
    logic [DEPTH_W-1:0] n_depth;
    t_result            n_res;
    t_result            r_res;
    logic [7:0]         r_char;
    logic               r_valid;
    logic               accept;

    pqst_step #(
        .MAX_NEST (MAX_NEST),
        .DEPTH_W  (DEPTH_W)
    ) u_step (
        .i_char  (i_s_tdata),
        .i_last  (i_s_tlast),
        .i_mode  (r_mode),
        .i_depth (r_depth),
        .o_mode  (n_mode),
        .o_depth (n_depth),
        .o_res   (n_res)
    );

    assign o_s_tready = !r_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_mode  <= MODE_IDLE;
            r_depth <= '0;
        end else if (accept) begin
            r_valid <= 1'b1;
            r_mode  <= n_mode;
            r_depth <= n_depth;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_char <= i_s_tdata;
            r_res  <= n_res;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_char;
    assign o_m_tuser  = {r_res.ovf, r_res.unterm, r_res.ended, r_res.close,
                         r_res.start, r_res.kind};

endmodule

@@ design/pqst_step.sv @@
// One scan step of the tokenizer: classifies a byte against the current
// mode and depth, gives the next mode, next depth and the result flags.
// Depends on pqst_pkg.
module pqst_step import pqst_pkg::*; #(
    parameter int MAX_NEST = 255,
    parameter int DEPTH_W  = 8
) (
    input  logic [7:0]         i_char,
    input  logic               i_last,
    input  t_mode              i_mode,
    input  logic [DEPTH_W-1:0] i_depth,
    output t_mode              o_mode,
    output logic [DEPTH_W-1:0] o_depth,
    output t_result            o_res
);

    localparam logic [DEPTH_W-1:0] MAX_D = DEPTH_W'(MAX_NEST);
    localparam logic [DEPTH_W-1:0] ONE_D = DEPTH_W'(1);

    t_mode              eff_mode;
    t_mode              mode_a;
    t_mode              mode_b;
    logic               word_end;
    logic [DEPTH_W-1:0] dec_depth;

    always_comb begin
        case (i_mode)
            MODE_WORD, MODE_GROUP, MODE_DQ, MODE_SQ: eff_mode = i_mode;
            default:                                 eff_mode = MODE_IDLE;
        endcase
        word_end = (eff_mode == MODE_WORD) && ends_word(i_char);
        mode_a   = word_end ? MODE_IDLE : eff_mode;
        dec_depth = (i_depth != '0) ? i_depth - ONE_D : i_depth;
    end

    // next state
    always_comb begin
        mode_b  = mode_a;
        o_depth = i_depth;
        case (mode_a)
            MODE_IDLE: begin
                if (i_char == CH_LPAREN) begin
                    mode_b  = MODE_GROUP;
                    o_depth = ONE_D;
                end else if (i_char == CH_DQUOTE) begin
                    mode_b = MODE_DQ;
                end else if (i_char == CH_SQUOTE) begin
                    mode_b = MODE_SQ;
                end else if (is_blank(i_char) || (i_char == CH_RPAREN)) begin
                    mode_b = MODE_IDLE;
                end else begin
                    mode_b = MODE_WORD;
                end
            end
            MODE_GROUP: begin
                if ((i_char == CH_LPAREN) && (i_depth < MAX_D)) begin
                    o_depth = i_depth + ONE_D;
                end else if (i_char == CH_RPAREN) begin
                    o_depth = dec_depth;
                    if (dec_depth == '0) begin
                        mode_b = MODE_IDLE;
                    end
                end
            end
            MODE_DQ: begin
                if (i_char == CH_DQUOTE) begin
                    mode_b = MODE_IDLE;
                end
            end
            MODE_SQ: begin
                if (i_char == CH_SQUOTE) begin
                    mode_b = MODE_IDLE;
                end
            end
            default: mode_b = mode_a;
        endcase
        o_mode = i_last ? MODE_IDLE : mode_b;
        if (o_mode != MODE_GROUP) begin
            o_depth = '0;
        end
    end

    // outputs
    always_comb begin
        o_res       = '0;
        o_res.kind  = KIND_NONE;
        o_res.ended = word_end;
        case (mode_a)
            MODE_WORD: o_res.kind = KIND_WORD;
            MODE_IDLE: begin
                if (is_blank(i_char)) begin
                    o_res.kind = KIND_NONE;
                end else if (i_char == CH_LPAREN) begin
                    o_res.kind  = KIND_GROUP;
                    o_res.start = 1'b1;
                end else if (i_char == CH_DQUOTE) begin
                    o_res.kind  = KIND_DQ;
                    o_res.start = 1'b1;
                end else if (i_char == CH_SQUOTE) begin
                    o_res.kind  = KIND_SQ;
                    o_res.start = 1'b1;
                end else if (i_char == CH_RPAREN) begin
                    o_res.kind  = KIND_WORD;
                    o_res.start = 1'b1;
                    o_res.close = 1'b1;
                end else begin
                    o_res.kind  = KIND_WORD;
                    o_res.start = 1'b1;
                end
            end
            MODE_GROUP: begin
                o_res.kind = KIND_GROUP;
                if ((i_char == CH_LPAREN) && (i_depth >= MAX_D)) begin
                    o_res.ovf = 1'b1;
                end
                if ((i_char == CH_RPAREN) && (i_depth <= ONE_D)) begin
                    o_res.close = 1'b1;
                end
            end
            MODE_DQ: begin
                o_res.kind = KIND_DQ;
                if (i_char == CH_DQUOTE) begin
                    o_res.close = 1'b1;
                end
            end
            MODE_SQ: begin
                o_res.kind = KIND_SQ;
                if (i_char == CH_SQUOTE) begin
                    o_res.close = 1'b1;
                end
            end
            default: o_res.kind = KIND_NONE;
        endcase
        if (i_last) begin
            if (mode_b == MODE_WORD) begin
                o_res.close = 1'b1;
            end else if (mode_b != MODE_IDLE) begin
                o_res.close  = 1'b1;
                o_res.unterm = 1'b1;
            end
        end
    end

endmodule

@@ design/pqst_checker.sv @@
// Port-level checker for the tokenizer, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module pqst_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic [7:0] i_s_tdata,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic [7:0] o_m_tuser
);

    `PQST_ASSERT(a_out_hold, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "stalled output beat changed")
    `PQST_ASSERT(a_beat_passes, i_s_tvalid && o_s_tready |=> o_m_tvalid && (o_m_tdata == $past(i_s_tdata)), "accepted beat not presented next cycle")
    `PQST_ASSERT_ALWAYS(a_ready_when_empty, !o_m_tvalid |-> o_s_tready, "input stalled with empty output")
    `PQST_ASSERT(a_unterm_closes, o_m_tvalid && o_m_tuser[6] |-> o_m_tuser[4] && (o_m_tuser[2:0] != 3'd0), "unterminated without close")
    `PQST_ASSERT(a_none_quiet, o_m_tvalid && (o_m_tuser[2:0] == 3'd0) |-> (o_m_tuser[7:3] & 5'b11011) == 5'b00000, "flags set on separator byte")

endmodule

bind paren_quote_space_tokenizer_unit pqst_checker u_pqst_checker (.*);
